// ===== sv/one_shot_timer_bank_macros.svh =====
// assertion macros for the one-shot timer bank
`ifndef ONE_SHOT_TIMER_BANK_MACROS_SVH
`define ONE_SHOT_TIMER_BANK_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define OSTB_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("timer bank check failed");
// next-cycle implication
`define OSTB_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("timer bank check failed");
`else
`define OSTB_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define OSTB_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

// ===== sv/ostb_pkg.sv =====
// types and constants shared by the one-shot timer bank
`timescale 1ns / 1ps
package ostb_pkg;

  localparam int TIMERS_DEF = 16;
  localparam int MAX_RES    = 16;
  localparam int CNT_W      = $clog2(MAX_RES + 1);
  localparam int IDX_W      = 6;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  localparam logic [1:0] EV_DONE    = 2'd0;
  localparam logic [1:0] EV_BAD_IDX = 2'd1;
  localparam logic [1:0] EV_EXPIRED = 2'd2;
  localparam logic [1:0] EV_STATUS  = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] timer_index;
    logic [31:0]      timeout_ticks;
    logic             notify;
    logic [7:0]       tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       event_res;
    logic [IDX_W-1:0] timer_index_res;
    logic [7:0]       tag_out;
    logic             is_active;
    logic             is_paused;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] deadline;
    logic        armed;
    logic        fires;
    logic [7:0]  tag;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== sv/ostb_if.sv =====
// valid/ready channel interfaces for command and result items
`timescale 1ns / 1ps
interface ostb_in_if import ostb_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ostb_out_if import ostb_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/ostb_mem.sv =====
// timer entry memory with per-entry valid bits and registered read
`timescale 1ns / 1ps
module ostb_mem import ostb_pkg::*; #(
  parameter int TIMERS = TIMERS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output entry_t   rd_entry
);

  localparam int AW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  entry_t            mem_r [TIMERS];
  entry_t            rd_raw_r;
  logic              rd_vld_r;
  logic [TIMERS-1:0] valid_r;

  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  assign waddr = req.waddr[AW-1:0];
  assign raddr = req.raddr[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_raw_r <= mem_r[raddr];
    end
  end

  // entries never written read with deadline, armed and fires cleared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (req.re) begin
        rd_vld_r <= valid_r[raddr];
      end
    end
  end

  assign rd_entry.deadline = rd_vld_r ? rd_raw_r.deadline : 32'd0;
  assign rd_entry.armed    = rd_vld_r & rd_raw_r.armed;
  assign rd_entry.fires    = rd_vld_r & rd_raw_r.fires;
  assign rd_entry.tag      = rd_raw_r.tag;

endmodule

// ===== sv/one_shot_timer_bank.sv =====
// one-shot timer bank: command sequencer, tick sweep and result register
//
// A bank of TIMERS one-shot timers on a shared 32-bit tick counter. Items carry a mode:
// tick advances the counter and sweeps the timers in index order, giving one expired
// result per armed, notifying timer whose deadline is strictly below the new time, at
// most MAX_RES per tick (last marks the final one; a tick with no expiry gives nothing);
// start, stop and query give exactly one result. Timer state sits in a single-port-read
// memory, so a tick reads one entry per cycle, stalling while a second expiry waits for
// the output register. After reset the bank is ready at once: valid bits mark the
// written entries, so no clearing pass is needed. A new item is taken whenever the
// sequencer is idle, even while the last result still waits in the output register.
`timescale 1ns / 1ps
`include "one_shot_timer_bank_macros.svh"
module one_shot_timer_bank import ostb_pkg::*; #(
  parameter int TIMERS = TIMERS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  ostb_in_if.sink     in_ch,
  ostb_out_if.source  out_ch
);

  localparam int CNTW = $clog2(TIMERS + 1);
  localparam logic [IDX_W:0] TIMERS_LIM = (IDX_W + 1)'(TIMERS);
  localparam logic [CNTW-1:0] SWEEP_END = CNTW'(TIMERS);
  localparam logic [CNT_W-1:0] RES_LIM = CNT_W'(MAX_RES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RESP  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]       state_r, state_nxt;
  in_item_t         cmd_r, cmd_nxt;
  logic             bad_r, bad_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [CNTW-1:0]  sweep_rd_r, sweep_rd_nxt;
  logic             eval_vld_r, eval_vld_nxt;
  logic [IDX_W-1:0] eval_idx_r, eval_idx_nxt;
  logic [CNT_W-1:0] exp_cnt_r, exp_cnt_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [7:0]       pend_tag_r, pend_tag_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_nxt;

  mem_req_t         mem_req;
  entry_t           rd_entry;
  logic             in_accept;
  logic             out_free;
  logic             out_load;
  logic             expire;
  logic             sweep_stall;
  logic [CNT_W-1:0] cnt_after;

  ostb_mem #(.TIMERS(TIMERS)) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .rd_entry (rd_entry)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  assign expire      = eval_vld_r && rd_entry.armed && rd_entry.fires &&
                       (rd_entry.deadline < now_r);
  // a second expiry needs the output register for the held one
  assign sweep_stall = expire && pend_vld_r && !out_free;
  assign cnt_after   = expire ? CNT_W'(exp_cnt_r + 1'b1) : exp_cnt_r;

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    bad_nxt      = bad_r;
    now_nxt      = now_r;
    sweep_rd_nxt = sweep_rd_r;
    eval_vld_nxt = eval_vld_r;
    eval_idx_nxt = eval_idx_r;
    exp_cnt_nxt  = exp_cnt_r;
    pend_vld_nxt = pend_vld_r;
    pend_idx_nxt = pend_idx_r;
    pend_tag_nxt = pend_tag_r;
    out_load     = 1'b0;
    out_nxt      = out_item_r;
    mem_req      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_nxt = in_ch.data;
          bad_nxt = (in_ch.data.mode != MODE_TICK) &&
                    ({1'b0, in_ch.data.timer_index} >= TIMERS_LIM);
          if (in_ch.data.mode == MODE_TICK) begin
            now_nxt      = now_r + 32'd1;
            sweep_rd_nxt = '0;
            eval_vld_nxt = 1'b0;
            exp_cnt_nxt  = '0;
            pend_vld_nxt = 1'b0;
            state_nxt    = ST_SWEEP;
          end else begin
            state_nxt     = ST_RESP;
            mem_req.waddr = in_ch.data.timer_index;
            mem_req.raddr = in_ch.data.timer_index;
            if (!bad_nxt) begin
              unique case (in_ch.data.mode)
                MODE_START: begin
                  mem_req.we             = 1'b1;
                  mem_req.wdata.deadline = now_r + in_ch.data.timeout_ticks;
                  mem_req.wdata.armed    = 1'b1;
                  mem_req.wdata.fires    = in_ch.data.notify;
                  mem_req.wdata.tag      = in_ch.data.tag;
                end
                MODE_STOP: begin
                  // fires and tag matter only once armed again by a start
                  mem_req.we             = 1'b1;
                  mem_req.wdata.deadline = 32'd0;
                  mem_req.wdata.armed    = 1'b0;
                  mem_req.wdata.fires    = 1'b0;
                  mem_req.wdata.tag      = in_ch.data.tag;
                end
                MODE_QUERY: begin
                  mem_req.re = 1'b1;
                end
                default: begin
                end
              endcase
            end
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_load                = 1'b1;
          out_nxt.timer_index_res = cmd_r.timer_index;
          out_nxt.tag_out         = 8'd0;
          out_nxt.last            = 1'b1;
          out_nxt.is_active       = 1'b0;
          out_nxt.is_paused       = 1'b0;
          if (bad_r) begin
            out_nxt.event_res = EV_BAD_IDX;
          end else if (cmd_r.mode == MODE_QUERY) begin
            out_nxt.event_res = EV_STATUS;
            out_nxt.is_active = rd_entry.armed;
            out_nxt.is_paused = !rd_entry.armed && (now_r < rd_entry.deadline);
          end else begin
            out_nxt.event_res = EV_DONE;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_SWEEP: begin
        if (!sweep_stall) begin
          if (expire) begin
            mem_req.we             = 1'b1;
            mem_req.waddr          = eval_idx_r;
            mem_req.wdata.deadline = rd_entry.deadline;
            mem_req.wdata.armed    = 1'b0;
            mem_req.wdata.fires    = rd_entry.fires;
            mem_req.wdata.tag      = rd_entry.tag;
            exp_cnt_nxt            = cnt_after;
            if (pend_vld_r) begin
              out_load                = 1'b1;
              out_nxt.event_res       = EV_EXPIRED;
              out_nxt.timer_index_res = pend_idx_r;
              out_nxt.tag_out         = pend_tag_r;
              out_nxt.is_active       = 1'b0;
              out_nxt.is_paused       = 1'b0;
              out_nxt.last            = 1'b0;
            end
            pend_vld_nxt = 1'b1;
            pend_idx_nxt = eval_idx_r;
            pend_tag_nxt = rd_entry.tag;
          end
          // read the next entry while this one is judged
          if ((sweep_rd_r < SWEEP_END) && (cnt_after < RES_LIM)) begin
            mem_req.re   = 1'b1;
            mem_req.raddr = IDX_W'(sweep_rd_r);
            eval_vld_nxt = 1'b1;
            eval_idx_nxt = IDX_W'(sweep_rd_r);
            sweep_rd_nxt = CNTW'(sweep_rd_r + 1'b1);
          end else begin
            eval_vld_nxt = 1'b0;
            state_nxt    = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_vld_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_load                = 1'b1;
          out_nxt.event_res       = EV_EXPIRED;
          out_nxt.timer_index_res = pend_idx_r;
          out_nxt.tag_out         = pend_tag_r;
          out_nxt.is_active       = 1'b0;
          out_nxt.is_paused       = 1'b0;
          out_nxt.last            = 1'b1;
          pend_vld_nxt            = 1'b0;
          state_nxt               = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= 32'd0;
      eval_vld_r  <= 1'b0;
      exp_cnt_r   <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sweep_rd_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      eval_vld_r  <= eval_vld_nxt;
      exp_cnt_r   <= exp_cnt_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      sweep_rd_r  <= sweep_rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    bad_r      <= bad_nxt;
    eval_idx_r <= eval_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_tag_r <= pend_tag_nxt;
    if (out_load) begin
      out_item_r <= out_nxt;
    end
  end

  `OSTB_ASSERT_IMP(a_expiry_in_sweep, clk, rst_n,
    out_load && out_nxt.event_res == EV_EXPIRED,
    state_r == ST_SWEEP || state_r == ST_FLUSH)
  `OSTB_ASSERT_NXT(a_cmd_to_resp, clk, rst_n,
    in_accept && in_ch.data.mode != MODE_TICK, state_r == ST_RESP)
  `OSTB_ASSERT_NXT(a_stall_holds_entry, clk, rst_n,
    state_r == ST_SWEEP && sweep_stall, $stable(rd_entry) && eval_vld_r)
  `OSTB_ASSERT_IMP(a_expiry_bound, clk, rst_n,
    state_r == ST_SWEEP, exp_cnt_r <= RES_LIM)

endmodule

// ===== tb/sv/one_shot_timer_bank_tb.sv =====
// testbench for the one-shot timer bank: directed table, random commands, scoreboard check
`timescale 1ns / 1ps
module one_shot_timer_bank_tb;
  import ostb_pkg::*;

  localparam int NTIMERS     = TIMERS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYC   = 2 * NTIMERS + 8;

  typedef struct packed {
    in_item_t  cmd;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  ostb_in_if  in_ch ();
  ostb_out_if out_ch ();

  one_shot_timer_bank #(.TIMERS(NTIMERS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // local copy of the timer bank
  logic [31:0] tick_now;
  logic [31:0] tmr_deadline [NTIMERS];
  logic        tmr_armed    [NTIMERS];
  logic        tmr_fires    [NTIMERS];
  logic [7:0]  tmr_tag      [NTIMERS];

  out_item_t step_q [$];
  out_item_t pending_q [$];
  dir_row_t  dir_tab [$];

  bit src_gaps;
  bit sink_stalls;
  int errs = 0;
  int n_sent;
  int n_checked = 0;
  int n_expired = 0;
  int n_bad_idx = 0;
  int n_status = 0;
  int peak_burst;
  int cyc = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cyc, pending_q.size());
      $display("one_shot_timer_bank_tb: FAIL");
      $finish;
    end
  end

  function automatic void predict_cmd(input in_item_t c);
    out_item_t r;
    int n;
    step_q.delete();
    n = 0;
    if (c.mode == MODE_TICK) begin
      tick_now = tick_now + 32'd1;
      for (int i = 0; i < NTIMERS && n < MAX_RES; i++) begin
        if (tmr_armed[i] && tmr_fires[i] && tmr_deadline[i] < tick_now) begin
          tmr_armed[i] = 1'b0;
          r = '0;
          r.event_res = EV_EXPIRED;
          r.timer_index_res = IDX_W'(i);
          r.tag_out = tmr_tag[i];
          step_q.push_back(r);
          n++;
        end
      end
      if (n > 0) step_q[n-1].last = 1'b1;
      return;
    end
    r = '0;
    r.timer_index_res = c.timer_index;
    r.last = 1'b1;
    if (c.timer_index >= NTIMERS) begin
      r.event_res = EV_BAD_IDX;
    end else begin
      case (c.mode)
        MODE_START: begin
          tmr_deadline[c.timer_index] = tick_now + c.timeout_ticks;
          tmr_armed[c.timer_index] = 1'b1;
          tmr_fires[c.timer_index] = c.notify;
          tmr_tag[c.timer_index] = c.tag;
          r.event_res = EV_DONE;
        end
        MODE_STOP: begin
          tmr_deadline[c.timer_index] = '0;
          tmr_armed[c.timer_index] = 1'b0;
          r.event_res = EV_DONE;
        end
        default: begin
          r.event_res = EV_STATUS;
          r.is_active = tmr_armed[c.timer_index];
          r.is_paused = !tmr_armed[c.timer_index] &&
                        (tick_now < tmr_deadline[c.timer_index]);
        end
      endcase
    end
    step_q.push_back(r);
  endfunction

  function automatic void add_row(input logic [1:0] md, input logic [IDX_W-1:0] ix,
                                  input logic [31:0] tmo, input logic nt,
                                  input logic [7:0] tg, input logic typed,
                                  input logic [1:0] ev, input logic act);
    dir_row_t d;
    d = '0;
    d.cmd.mode = md;
    d.cmd.timer_index = ix;
    d.cmd.timeout_ticks = tmo;
    d.cmd.notify = nt;
    d.cmd.tag = tg;
    d.typed = typed;
    d.want.event_res = ev;
    d.want.timer_index_res = ix;
    d.want.is_active = act;
    d.want.last = 1'b1;
    dir_tab.push_back(d);
  endfunction

  function automatic in_item_t rand_cmd();
    in_item_t c;
    int unsigned r;
    r = $urandom_range(0, 99);
    c.mode = MODE_TICK;
    c.timer_index = IDX_W'($urandom_range(0, 63));
    c.timeout_ticks = $urandom;
    c.notify = 1'($urandom_range(0, 1));
    c.tag = 8'($urandom_range(0, 255));
    if (r < 35) begin
      c.mode = MODE_TICK;  // remaining fields are noise on a tick
    end else if (r < 70) begin
      c.mode = MODE_START;
      c.timer_index = IDX_W'($urandom_range(0, NTIMERS - 1));
      c.notify = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 7))
        0: ;  // full range timeout, usually never expires
        // deadline wraps behind now
        1: c.timeout_ticks = 32'hFFFF_FFFF - $urandom_range(0, 3);
        default: c.timeout_ticks = $urandom_range(0, 8);
      endcase
    end else if (r < 80) begin
      c.mode = MODE_STOP;
      c.timer_index = IDX_W'($urandom_range(0, NTIMERS - 1));
    end else if (r < 92) begin
      c.mode = MODE_QUERY;
      c.timer_index = IDX_W'($urandom_range(0, NTIMERS - 1));
    end else begin
      case ($urandom_range(0, 2))
        0: c.mode = MODE_START;
        1: c.mode = MODE_STOP;
        default: c.mode = MODE_QUERY;
      endcase
      c.timer_index = IDX_W'($urandom_range(NTIMERS, 63));
    end
    return c;
  endfunction

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_cmd(input in_item_t c, input logic typed, input out_item_t want);
    int unsigned gap;
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= c;
    do @(posedge clk); while (!in_ch.ready);
    predict_cmd(c);
    if (c.mode == MODE_TICK && step_q.size() > peak_burst) peak_burst = step_q.size();
    if (typed) pending_q.push_back(want);
    else foreach (step_q[k]) pending_q.push_back(step_q[k]);
    n_sent++;
  endtask

  task automatic arm_all(input int unsigned max_tmo);
    in_item_t c;
    for (int i = 0; i < NTIMERS; i++) begin
      c.mode = MODE_START;
      c.timer_index = IDX_W'(i);
      c.timeout_ticks = $urandom_range(0, max_tmo);
      c.notify = 1'b1;
      c.tag = 8'($urandom_range(0, 255));
      send_cmd(c, 1'b0, '0);
    end
    c = '0;
    c.mode = MODE_TICK;
    repeat (max_tmo + 2) send_cmd(c, 1'b0, '0);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_cmd(rand_cmd(), 1'b0, '0);
  endtask

  // result sink: random stall bursts while enabled
  initial begin : result_sink
    int unsigned hold;
    out_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold != 0) begin
        hold--;
      end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(1, 15) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    out_item_t got;
    bit bad;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      n_checked++;
      case (got.event_res)
        EV_EXPIRED: n_expired++;
        EV_BAD_IDX: n_bad_idx++;
        EV_STATUS:  n_status++;
        default: ;
      endcase
      if (pending_q.size() == 0) begin
        $error("unexpected result: event_res %0d timer_index_res %0d",
               got.event_res, got.timer_index_res);
        errs++;
      end else begin
        want = pending_q.pop_front();
        bad = 1'b0;
        if (got.event_res !== want.event_res) begin
          $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
          bad = 1'b1;
        end
        if (got.timer_index_res !== want.timer_index_res) begin
          $error("timer_index_res: expected %0d, got %0d",
                 want.timer_index_res, got.timer_index_res);
          bad = 1'b1;
        end
        if (got.tag_out !== want.tag_out) begin
          $error("tag_out: expected %0d, got %0d", want.tag_out, got.tag_out);
          bad = 1'b1;
        end
        if (got.is_active !== want.is_active) begin
          $error("is_active: expected %0d, got %0d", want.is_active, got.is_active);
          bad = 1'b1;
        end
        if (got.is_paused !== want.is_paused) begin
          $error("is_paused: expected %0d, got %0d", want.is_paused, got.is_paused);
          bad = 1'b1;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          bad = 1'b1;
        end
        if (bad) errs++;
      end
    end
  end

  initial begin : stimulus
    n_sent = 0;
    peak_burst = 0;
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    tick_now = '0;
    for (int i = 0; i < NTIMERS; i++) begin
      tmr_deadline[i] = '0;
      tmr_armed[i] = 1'b0;
      tmr_fires[i] = 1'b0;
      tmr_tag[i] = '0;
    end

    //      mode        idx    timeout        ntf   tag    typed ev          act
    add_row(MODE_QUERY, 6'd0,  32'd0,         1'b0, 8'h00, 1'b1, EV_STATUS,  1'b0);
    add_row(MODE_TICK,  6'd63, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b0, EV_DONE,    1'b0);
    add_row(MODE_START, 6'd0,  32'd0,         1'b1, 8'hFF, 1'b1, EV_DONE,    1'b0);
    add_row(MODE_START, 6'd15, 32'hFFFF_FFFF, 1'b1, 8'h00, 1'b1, EV_DONE,    1'b0);
    add_row(MODE_START, 6'd16, 32'd5,         1'b1, 8'h11, 1'b1, EV_BAD_IDX, 1'b0);
    add_row(MODE_STOP,  6'd63, 32'd0,         1'b0, 8'h00, 1'b1, EV_BAD_IDX, 1'b0);
    add_row(MODE_QUERY, 6'd32, 32'd0,         1'b0, 8'h00, 1'b1, EV_BAD_IDX, 1'b0);
    add_row(MODE_START, 6'd7,  32'd1,         1'b0, 8'hA5, 1'b1, EV_DONE,    1'b0);
    add_row(MODE_START, 6'd3,  32'd1,         1'b1, 8'h5A, 1'b1, EV_DONE,    1'b0);
    add_row(MODE_QUERY, 6'd0,  32'd0,         1'b0, 8'h00, 1'b1, EV_STATUS,  1'b1);
    // first and last timer expire together, timer 3 sits exactly on its deadline
    add_row(MODE_TICK,  6'd0,  32'd0,         1'b0, 8'h00, 1'b0, EV_DONE,    1'b0);
    add_row(MODE_QUERY, 6'd0,  32'd0,         1'b0, 8'h00, 1'b0, EV_DONE,    1'b0);
    add_row(MODE_TICK,  6'd21, 32'd9,         1'b1, 8'h42, 1'b0, EV_DONE,    1'b0);
    add_row(MODE_TICK,  6'd42, 32'd0,         1'b0, 8'h24, 1'b0, EV_DONE,    1'b0);
    // non-notifying timer stays armed
    add_row(MODE_QUERY, 6'd7,  32'd0,         1'b0, 8'h00, 1'b0, EV_DONE,    1'b0);
    add_row(MODE_STOP,  6'd7,  32'd0,         1'b0, 8'h00, 1'b1, EV_DONE,    1'b0);
    add_row(MODE_QUERY, 6'd7,  32'd0,         1'b0, 8'h00, 1'b0, EV_DONE,    1'b0);
    add_row(MODE_START, 6'd5,  32'h8000_0000, 1'b1, 8'h3C, 1'b1, EV_DONE,    1'b0);
    add_row(MODE_QUERY, 6'd5,  32'd0,         1'b0, 8'h00, 1'b0, EV_DONE,    1'b0);
    add_row(MODE_STOP,  6'd5,  32'd0,         1'b0, 8'h00, 1'b1, EV_DONE,    1'b0);
    add_row(MODE_QUERY, 6'd5,  32'd0,         1'b0, 8'h00, 1'b0, EV_DONE,    1'b0);
    // restart of an expired timer
    add_row(MODE_START, 6'd0,  32'd0,         1'b1, 8'h00, 1'b1, EV_DONE,    1'b0);
    add_row(MODE_TICK,  6'd0,  32'd0,         1'b0, 8'h00, 1'b0, EV_DONE,    1'b0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[k]) send_cmd(dir_tab[k].cmd, dir_tab[k].typed, dir_tab[k].want);

    run_random(25);

    // hold the sender until the bank has answered everything
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    @(posedge clk);

    arm_all(0);  // every timer expires on the same tick
    run_random(20);

    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    arm_all(2);
    run_random(5);

    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("sent %0d command items, checked %0d results", n_sent, n_checked);
    $display("%0d expiries, %0d bad index, %0d status, biggest tick burst %0d, ticks %0d",
             n_expired, n_bad_idx, n_status, peak_burst, tick_now);
    if (errs == 0) begin
      $display("one_shot_timer_bank_tb: PASS");
    end else begin
      $display("one_shot_timer_bank_tb: FAIL");
    end
    $finish;
  end

endmodule
